[src/etb_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// etb_pkg: shared types and constants of the elimination tree builder
// Node and register widths, the ancestor memory entry and the memory and
// result bundles passed between the walk controller and its neighbors.
// ----------------------------------------------------------------------------
package etb_pkg;

    localparam int NODE_W        = 10;
    localparam int NODE_COUNT    = 1 << NODE_W;
    localparam int CFG_W         = 11;
    localparam int MAX_NODES_DEF = 1024;
    localparam logic [CFG_W-1:0] NODES_IN_USE_RST = 11'd1024;

    // One ancestor memory entry: valid mark plus stored ancestor
    typedef struct packed {
        logic              valid;
        logic [NODE_W-1:0] anc;
    } entry_t;

    // Memory request from the walk controller
    typedef struct packed {
        logic              we;
        logic [NODE_W-1:0] waddr;
        entry_t            wdata;
        logic [NODE_W-1:0] raddr;
    } mem_req_t;

    // Result produced at the end of a walk
    typedef struct packed {
        logic              valid;
        logic [NODE_W-1:0] child;
        logic [NODE_W-1:0] parent;
    } res_t;

endpackage
`default_nettype wire

[src/etb_anc_mem.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// etb_anc_mem: ancestor memory
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module etb_anc_mem #(
    parameter int MAX_NODES = etb_pkg::MAX_NODES_DEF
) (
    input  wire logic             clk,
    input  wire etb_pkg::mem_req_t req,
    output etb_pkg::entry_t       rdata_reg
);

    localparam int DEPTH  = (MAX_NODES < etb_pkg::NODE_COUNT) ? MAX_NODES
                                                              : etb_pkg::NODE_COUNT;
    localparam int ADDR_W = $clog2(DEPTH);

    etb_pkg::entry_t anc_mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            anc_mem[req.waddr[ADDR_W-1:0]] <= req.wdata;
        end
        rdata_reg <= anc_mem[req.raddr[ADDR_W-1:0]];
    end

endmodule
`default_nettype wire

[src/etb_walk_ctrl.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// etb_walk_ctrl: ancestor walk sequencer
// Accepts entries, sweeps the valid marks on reset and on matrix start,
// walks the ancestor path one node per cycle with read-modify-write.
// ----------------------------------------------------------------------------
module etb_walk_ctrl #(
    parameter int MAX_NODES = etb_pkg::MAX_NODES_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    output logic                             in_stall,
    input  wire logic [etb_pkg::NODE_W-1:0]  row_index,
    input  wire logic [etb_pkg::NODE_W-1:0]  column_index,
    input  wire logic                        matrix_start,
    input  wire logic [etb_pkg::CFG_W-1:0]   nodes_in_use,
    input  wire logic                        out_full,
    input  wire etb_pkg::entry_t             rdata,
    output etb_pkg::mem_req_t                req,
    output etb_pkg::res_t                    res
);

    localparam int DEPTH  = (MAX_NODES < etb_pkg::NODE_COUNT) ? MAX_NODES
                                                              : etb_pkg::NODE_COUNT;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);
    localparam logic [etb_pkg::CFG_W-1:0] DEPTH_LIM = etb_pkg::CFG_W'(DEPTH);

    typedef enum logic [3:0] {
        ST_CLEAR  = 4'b0001,
        ST_IDLE   = 4'b0010,
        ST_LAUNCH = 4'b0100,
        ST_WALK   = 4'b1000
    } state_t;

    state_t                     state_reg, state_next;
    logic [ADDR_W-1:0]          clr_cnt_reg, clr_cnt_next;
    logic                       pend_reg, pend_next;
    logic [etb_pkg::NODE_W-1:0] row_reg, row_next;
    logic [etb_pkg::NODE_W-1:0] col_reg, col_next;
    logic [etb_pkg::NODE_W-1:0] node_reg, node_next;
    logic                       in_fire;
    logic                       ignore;

    assign in_stall = (state_reg != ST_IDLE);
    assign in_fire  = in_valid && !in_stall;

    assign ignore = (row_reg >= col_reg)
                 || ({1'b0, row_reg} >= nodes_in_use)
                 || ({1'b0, col_reg} >= nodes_in_use)
                 || ({1'b0, row_reg} >= DEPTH_LIM)
                 || ({1'b0, col_reg} >= DEPTH_LIM);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_CLEAR;
            clr_cnt_reg <= '0;
            pend_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            pend_reg    <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        row_reg  <= row_next;
        col_reg  <= col_next;
        node_reg <= node_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        clr_cnt_next   = clr_cnt_reg;
        pend_next      = pend_reg;
        row_next       = row_reg;
        col_next       = col_reg;
        node_next      = node_reg;
        req.we         = 1'b0;
        req.waddr      = node_reg;
        req.wdata.valid = 1'b1;
        req.wdata.anc  = col_reg;
        req.raddr      = node_reg;
        res.valid      = 1'b0;
        res.child      = node_reg;
        res.parent     = col_reg;

        unique case (state_reg)
            ST_CLEAR:
            begin
                req.we          = 1'b1;
                req.waddr       = etb_pkg::NODE_W'(clr_cnt_reg);
                req.wdata.valid = 1'b0;
                req.wdata.anc   = '0;
                clr_cnt_next    = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == LAST_ADDR)
                begin
                    clr_cnt_next = '0;
                    pend_next    = 1'b0;
                    state_next   = pend_reg ? ST_LAUNCH : ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    row_next = row_index;
                    col_next = column_index;
                    if (matrix_start)
                    begin
                        pend_next  = 1'b1;
                        state_next = ST_CLEAR;
                    end
                    else
                    begin
                        state_next = ST_LAUNCH;
                    end
                end
            end
            ST_LAUNCH:
            begin
                if (ignore)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    req.raddr  = row_reg;
                    node_next  = row_reg;
                    state_next = ST_WALK;
                end
            end
            ST_WALK:
            begin
                if (!rdata.valid)
                begin
                    // hold and reread until the result slot frees up
                    if (!out_full)
                    begin
                        req.we     = 1'b1;
                        res.valid  = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
                else
                begin
                    // compress: point this node at the column, advance
                    req.we = 1'b1;
                    if (rdata.anc < col_reg)
                    begin
                        req.raddr = rdata.anc;
                        node_next = rdata.anc;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    a_walk_below_col: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_WALK |-> node_reg < col_reg)
        else $error("walk node not below column");

    a_res_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid |-> !out_full)
        else $error("result issued into a full output slot");

    a_res_ends_walk: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid |=> state_reg == ST_IDLE)
        else $error("walk did not end after its result");

    a_walk_advances: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WALK && rdata.valid && rdata.anc < col_reg)
        |=> node_reg > $past(node_reg))
        else $error("walk did not move up the tree");

endmodule
`default_nettype wire

[src/elimination_tree_builder.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// elimination_tree_builder: elimination tree of a symmetric sparse matrix
// Top level: configuration register, output register, walk controller and
// ancestor memory.
// ----------------------------------------------------------------------------
// Each input beat is one stored entry (row, column), columns nondecreasing.
// An entry is accepted in the idle state, the launch state issues the first
// ancestor memory read, then the walk visits one node per cycle on the
// compressed path, each visit being one read and one write on the ancestor
// memory port pair; an ignored entry returns to idle from the launch state.
// Reset and every beat with matrix_start set sweep the valid marks,
// min(MAX_NODES, 1024) of them (1024 by default), before that entry is
// processed, while the input stays stalled. A result beat (child, parent)
// waits in an output register; the next entry is accepted while it stalls.
// ----------------------------------------------------------------------------
module elimination_tree_builder #(
    parameter int MAX_NODES = etb_pkg::MAX_NODES_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        cfg_wr_en,
    input  wire logic [etb_pkg::CFG_W-1:0]   cfg_wr_data,
    input  wire logic                        in_valid,
    output logic                             in_stall,
    input  wire logic [etb_pkg::NODE_W-1:0]  row_index,
    input  wire logic [etb_pkg::NODE_W-1:0]  column_index,
    input  wire logic                        matrix_start,
    output logic                             out_valid,
    input  wire logic                        out_stall,
    output logic [etb_pkg::NODE_W-1:0]       child_node,
    output logic [etb_pkg::NODE_W-1:0]       parent_node
);

    logic [etb_pkg::CFG_W-1:0]  nodes_in_use_reg;
    logic                       out_valid_reg;
    logic [etb_pkg::NODE_W-1:0] child_reg;
    logic [etb_pkg::NODE_W-1:0] parent_reg;
    logic                       out_full;
    etb_pkg::mem_req_t          req;
    etb_pkg::entry_t            rdata;
    etb_pkg::res_t              res;

    assign out_full    = out_valid_reg && out_stall;
    assign out_valid   = out_valid_reg;
    assign child_node  = child_reg;
    assign parent_node = parent_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nodes_in_use_reg <= etb_pkg::NODES_IN_USE_RST;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                nodes_in_use_reg <= cfg_wr_data;
            end
            if (res.valid)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (res.valid)
        begin
            child_reg  <= res.child;
            parent_reg <= res.parent;
        end
    end

    etb_walk_ctrl #(
        .MAX_NODES(MAX_NODES)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .row_index   (row_index),
        .column_index(column_index),
        .matrix_start(matrix_start),
        .nodes_in_use(nodes_in_use_reg),
        .out_full    (out_full),
        .rdata       (rdata),
        .req         (req),
        .res         (res)
    );

    etb_anc_mem #(
        .MAX_NODES(MAX_NODES)
    ) u_mem (
        .clk      (clk),
        .req      (req),
        .rdata_reg(rdata)
    );

endmodule
`default_nettype wire

[dv/elimination_tree_builder_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// elimination_tree_builder_test: self-checking bench for the tree builder
// Drives stored matrix entries through the input channel. An in-bench copy
// of the ancestor store predicts each (child, parent) beat, and every output
// beat is checked in order. Directed walks come first, then random matrices
// under several node limits, with random idling on both channels.
// ----------------------------------------------------------------------------
module elimination_tree_builder_test;

    // reset sweep or start sweep plus the longest capped walk, with margin
    localparam int SETTLE_CYCLES = 2100;
    localparam int MAX_SHOWN     = 10;

    typedef struct packed {
        logic [etb_pkg::NODE_W-1:0] child;
        logic [etb_pkg::NODE_W-1:0] parent;
    } tree_link_t;

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       cfg_wr_en = 1'b0;
    logic [etb_pkg::CFG_W-1:0]  cfg_wr_data = '0;
    logic                       in_valid = 1'b0;
    logic                       in_stall;
    logic [etb_pkg::NODE_W-1:0] row_index = '0;
    logic [etb_pkg::NODE_W-1:0] column_index = '0;
    logic                       matrix_start = 1'b0;
    logic                       out_valid;
    logic                       out_stall = 1'b0;
    logic [etb_pkg::NODE_W-1:0] child_node;
    logic [etb_pkg::NODE_W-1:0] parent_node;

    // predictor state
    logic [etb_pkg::NODE_W-1:0] anc_node [etb_pkg::NODE_COUNT];
    bit                         anc_mark [etb_pkg::NODE_COUNT];
    logic [etb_pkg::CFG_W-1:0]  node_limit = etb_pkg::NODES_IN_USE_RST;

    tree_link_t  pending_links[$];
    int unsigned mismatch_count = 0;
    int unsigned useful_beats = 0;
    int unsigned stall_left = 0;
    bit          steady = 1'b0;
    tree_link_t  got_link;
    tree_link_t  want_link;

    elimination_tree_builder u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .row_index    (row_index),
        .column_index (column_index),
        .matrix_start (matrix_start),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .child_node   (child_node),
        .parent_node  (parent_node)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    initial
    begin
        #2000000;
        $display("elimination_tree_builder regression: fail");
        $finish;
    end

    // Walk from the row toward the column, compressing every node visited.
    function automatic bit find_tree_parent(input logic [etb_pkg::NODE_W-1:0] row,
                                            input logic [etb_pkg::NODE_W-1:0] col,
                                            input bit start,
                                            output tree_link_t link);
        int unsigned node;
        int unsigned visits;
        logic [etb_pkg::NODE_W-1:0] next;
        if (start)
            anc_mark = '{default: 1'b0};
        link = '0;
        if (row >= col || row >= node_limit || col >= node_limit)
            return 1'b0;
        node = row;
        for (visits = 0; visits < etb_pkg::NODE_COUNT && node < col; visits++)
        begin
            if (anc_mark[node])
            begin
                next = anc_node[node];
                anc_node[node] = col;
                node = next;
            end
            else
            begin
                anc_node[node] = col;
                anc_mark[node] = 1'b1;
                link.child = node[etb_pkg::NODE_W-1:0];
                link.parent = col;
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    function automatic void note_failure(input string msg);
        mismatch_count++;
        if (mismatch_count <= MAX_SHOWN)
            $display("[%0t] %s", $realtime, msg);
    endfunction

    function automatic int unsigned pick_gap();
        int unsigned roll;
        if (steady)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            return 0;
        if (roll < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Result side: check each accepted beat, then pick the next stall.
    always @(posedge clk)
    begin
        if (out_valid && !out_stall)
        begin
            got_link.child = child_node;
            got_link.parent = parent_node;
            if (pending_links.size() == 0)
                note_failure($sformatf("unexpected beat child=%0d parent=%0d",
                                       child_node, parent_node));
            else
            begin
                want_link = pending_links.pop_front();
                if (got_link.child !== want_link.child)
                    note_failure($sformatf("child_node expected %0d got %0d",
                                           want_link.child, got_link.child));
                if (got_link.parent !== want_link.parent)
                    note_failure($sformatf("parent_node expected %0d got %0d",
                                           want_link.parent, got_link.parent));
            end
        end
        if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            out_stall <= 1'b1;
        end
        else if (steady || $urandom_range(0, 99) < 70)
            out_stall <= 1'b0;
        else
        begin
            out_stall <= 1'b1;
            if ($urandom_range(0, 9) == 0)
                stall_left <= $urandom_range(10, 60);
            else
                stall_left <= $urandom_range(0, 3);
        end
    end

    // Hold the beat until accepted; lower valid only when a gap follows.
    task automatic send_entry(input logic [etb_pkg::NODE_W-1:0] row,
                              input logic [etb_pkg::NODE_W-1:0] col,
                              input bit start, input int unsigned gap);
        tree_link_t link;
        in_valid <= 1'b1;
        row_index <= row;
        column_index <= col;
        matrix_start <= start;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        if (row < col && col < node_limit)
            useful_beats++;
        if (find_tree_parent(row, col, start, link))
            pending_links.push_back(link);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        while (pending_links.size() != 0)
            @(posedge clk);
    endtask

    task automatic set_node_count(input int unsigned count);
        drain_results();
        // let any sweep or walk with no result finish
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= count[etb_pkg::CFG_W-1:0];
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        node_limit = count[etb_pkg::CFG_W-1:0];
    endtask

    task automatic test_directed_walks();
        set_node_count(1024);
        send_entry(10'd0, 10'd1, 1'b1, 0);
        send_entry(10'd1, 10'd1023, 1'b0, 0);
        // walk runs into the column through compressed ancestors
        send_entry(10'd0, 10'd1023, 1'b0, 1);
        send_entry(10'd1022, 10'd1023, 1'b0, 0);
        send_entry(10'd3, 10'd4, 1'b0, 0);
        // column lower than the last one
        send_entry(10'd2, 10'd3, 1'b0, 2);
        send_entry(10'd2, 10'd1000, 1'b0, 0);
        send_entry(10'd3, 10'd1000, 1'b0, 0);
        send_entry(10'h2AA, 10'h355, 1'b0, 0);
        send_entry(10'h155, 10'h3FE, 1'b0, 3);
    endtask

    task automatic test_ignored_entries();
        send_entry(10'd1023, 10'd1023, 1'b0, 0);
        send_entry(10'd1023, 10'd0, 1'b0, 0);
        send_entry(10'd512, 10'd511, 1'b0, 1);
        // start flag on an ignored beat still clears the marks
        send_entry(10'd7, 10'd7, 1'b1, 0);
        send_entry(10'd0, 10'd1, 1'b0, 0);
        send_entry(10'd5, 10'd3, 1'b1, 0);
        send_entry(10'd1, 10'd2, 1'b0, 0);
    endtask

    task automatic test_node_limit_extremes();
        set_node_count(1);
        send_entry(10'd0, 10'd1, 1'b0, 0);
        send_entry(10'd0, 10'd0, 1'b0, 0);
        set_node_count(2);
        send_entry(10'd0, 10'd1, 1'b1, 0);
        send_entry(10'd0, 10'd2, 1'b0, 0);
        send_entry(10'd1, 10'd2, 1'b0, 0);
        send_entry(10'd0, 10'd1, 1'b0, 0);
        set_node_count(1023);
        send_entry(10'd1022, 10'd1023, 1'b0, 0);
        send_entry(10'd1021, 10'd1022, 1'b1, 0);
    endtask

    // One matrix: nondecreasing columns with some noise mixed in.
    task automatic run_matrix(input int unsigned n, input int unsigned beats,
                              input int unsigned noise_pct);
        int unsigned col;
        int unsigned row;
        int unsigned alt_col;
        int unsigned step_max;
        bit start;
        col = 0;
        step_max = (2 * n) / beats + 1;
        for (int k = 0; k < beats; k++)
        begin
            start = (k == 0) || ($urandom_range(0, 199) == 0);
            if ($urandom_range(0, 99) < noise_pct)
            begin
                case ($urandom_range(0, 3))
                    0: send_entry(10'($urandom_range(col, 1023)), 10'(col), start, pick_gap());
                    1:
                    begin
                        if (node_limit < etb_pkg::NODE_COUNT)
                            alt_col = $urandom_range(node_limit, etb_pkg::NODE_COUNT - 1);
                        else
                            alt_col = $urandom_range(0, etb_pkg::NODE_COUNT - 1);
                        send_entry(10'($urandom_range(0, 1023)), 10'(alt_col), start,
                                   pick_gap());
                    end
                    2:
                    begin
                        alt_col = $urandom_range(0, col);
                        row = (alt_col > 0) ? $urandom_range(0, alt_col - 1) : 0;
                        send_entry(10'(row), 10'(alt_col), start, pick_gap());
                    end
                    default: send_entry(10'($urandom_range(0, 1023)),
                                        10'($urandom_range(0, 1023)), start, pick_gap());
                endcase
            end
            else
            begin
                col = col + $urandom_range(0, step_max);
                if (col >= n)
                    col = n - 1;
                if (col == 0 && n > 1)
                    col = 1;
                row = (col > 0) ? $urandom_range(0, col - 1) : 0;
                send_entry(10'(row), 10'(col), start, pick_gap());
            end
        end
    endtask

    task automatic test_random_matrices();
        int unsigned limits[7];
        int unsigned lim;
        int unsigned goal;
        int unsigned n;
        limits = '{1024, 1023, 1, 2, 0, 64, 1024};
        for (int p = 0; p < 7; p++)
        begin
            lim = (limits[p] == 0) ? $urandom_range(3, 1022) : limits[p];
            set_node_count(lim);
            steady = (p == 5);
            if (lim == 1)
                run_matrix(1, 12, 30);
            else
            begin
                goal = useful_beats + 80;
                while (useful_beats < goal)
                begin
                    if (lim < 3 || $urandom_range(0, 7) == 0)
                        n = lim;
                    else
                        n = $urandom_range(2, (lim > 64) ? 64 : lim);
                    run_matrix(n, $urandom_range(8, 40), 15);
                    // hold off the sender until the output side is empty
                    if (p == 4 && $urandom_range(0, 2) == 0)
                        drain_results();
                end
            end
            steady = 1'b0;
        end
    endtask

    initial
    begin
        anc_mark = '{default: 1'b0};
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        test_directed_walks();
        test_ignored_entries();
        test_node_limit_extremes();
        test_random_matrices();
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("elimination_tree_builder regression: pass");
        else
            $display("elimination_tree_builder regression: fail");
        $finish;
    end

endmodule
